@@ rtl/core/atsfs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and a helper function for the ATS frame synchronizer.
package atsfs_pkg;

  localparam int HEADER_BYTES = 8;
  localparam int WINDOW_W     = HEADER_BYTES * 8;
  localparam int LEN_W        = 14;

  localparam logic [15:0] RATE_32K = 16'd32000;
  localparam logic [15:0] RATE_44K = 16'd44100;
  localparam logic [15:0] RATE_48K = 16'd48000;

  localparam logic [2:0] RATE_IDX_32K = 3'd0;
  localparam logic [2:0] RATE_IDX_44K = 3'd1;
  localparam logic [2:0] RATE_IDX_48K = 3'd2;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             header_found;
    logic             frame_last;
    logic             in_frame;
    logic [15:0]      sample_rate_hz;
    logic [2:0]       channel_config;
    logic [LEN_W-1:0] frame_bytes;
  } result_t;

  function automatic logic [15:0] rate_hz(input logic [2:0] idx);
    logic [15:0] r;
    case (idx)
      RATE_IDX_32K: r = RATE_32K;
      RATE_IDX_44K: r = RATE_44K;
      RATE_IDX_48K: r = RATE_48K;
      default:      r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/atsfs_if.sv @@
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the byte input and the result output.
interface atsfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface atsfs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        header_found;
  logic        frame_last;
  logic        in_frame;
  logic [15:0] sample_rate_hz;
  logic [2:0]  channel_config;
  logic [13:0] frame_bytes;

  modport source (output valid, output out_byte, output header_found, output frame_last,
                  output in_frame, output sample_rate_hz, output channel_config,
                  output frame_bytes, input ready);
  modport sink   (input valid, input out_byte, input header_found, input frame_last,
                  input in_frame, input sample_rate_hz, input channel_config,
                  input frame_bytes, output ready);
endinterface

@@ rtl/core/ats_frame_sync_deframer.sv @@
`timescale 1ns / 1ps
// ATS frame synchronizer: finds frame headers in a byte stream and tracks frame ends.
//
// Usage: bytes enter on in_ch and leave, one result item per byte, on out_ch.
// While searching, each byte shifts into an 8-byte header window; a header is
// found when the top 16 bits match the sync word written on cfg_we/cfg_wdata
// and the rate and channel indexes are legal. The result item that completes
// the header carries the sample rate, channel configuration and frame length.
// The following bytes are counted and the last byte of the frame is flagged,
// after which the window is cleared and searching resumes.
// Each result is registered in the output register, or in the skid register on
// a stall; one item is taken every cycle while out_ch does not stall. The header
// compare and byte counter each fit between the state and output registers.
// Reset clears the window, the lock flag, the counter and the sync word.
// When the receiver stalls, one more item is held in a skid register, after
// which in_ch.ready drops until the output drains.
module ats_frame_sync_deframer (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  atsfs_in_if.sink          in_ch,
  atsfs_out_if.source       out_ch
);

  logic [15:0]                    sync_pattern;
  logic [atsfs_pkg::WINDOW_W-1:0] header_window;
  logic [atsfs_pkg::WINDOW_W-1:0] header_window_next;
  logic                           locked;
  logic                           locked_next;
  logic [atsfs_pkg::LEN_W-1:0]    bytes_left;
  logic [atsfs_pkg::LEN_W-1:0]    bytes_left_next;

  atsfs_pkg::result_t res;
  atsfs_pkg::result_t out_data;
  atsfs_pkg::result_t skid_data;
  logic               out_valid;
  logic               skid_valid;

  logic [atsfs_pkg::WINDOW_W-1:0] shifted;
  logic [2:0]                     ridx;
  logic [2:0]                     cidx;
  logic [9:0]                     lfld;
  logic                           match;
  logic                           in_fire;
  logic                           out_fire;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid && out_ch.ready;

  assign shifted = {header_window[atsfs_pkg::WINDOW_W-9:0], in_ch.data_byte};
  assign ridx    = shifted[47:45];
  assign cidx    = shifted[44:42];
  assign lfld    = shifted[41:32];
  assign match   = (shifted[63:48] == sync_pattern) && (ridx < 3'd3) && (cidx != 3'd0);

  always_comb begin
    header_window_next = header_window;
    locked_next        = locked;
    bytes_left_next    = bytes_left;
    res                = '0;
    res.out_byte       = in_ch.data_byte;
    if (!locked) begin
      header_window_next = shifted;
      if (match) begin
        res.header_found   = 1'b1;
        res.sample_rate_hz = atsfs_pkg::rate_hz(ridx);
        res.channel_config = cidx;
        // (L+1)*8 + 8 bytes in total; (L+1)*8 of them follow the header.
        res.frame_bytes    = {1'b0, lfld, 3'b000} + 14'd16;
        locked_next        = 1'b1;
        bytes_left_next    = {1'b0, lfld, 3'b000} + 14'd8;
      end
    end else begin
      res.in_frame = 1'b1;
      if (bytes_left <= 14'd1) begin
        res.frame_last     = 1'b1;
        locked_next        = 1'b0;
        bytes_left_next    = '0;
        header_window_next = '0;
      end else begin
        bytes_left_next = bytes_left - 14'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern  <= '0;
      header_window <= '0;
      locked        <= 1'b0;
      bytes_left    <= '0;
    end else begin
      if (cfg_we) begin
        sync_pattern <= cfg_wdata;
      end
      if (in_fire) begin
        header_window <= header_window_next;
        locked        <= locked_next;
        bytes_left    <= bytes_left_next;
      end
    end
  end

  // Output register with a one-entry skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ch.ready) begin
      out_valid  <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ch.ready) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (in_fire) begin
      skid_data <= res;
    end
  end

  assign in_ch.ready           = !skid_valid;
  assign out_ch.valid          = out_valid;
  assign out_ch.out_byte       = out_data.out_byte;
  assign out_ch.header_found   = out_data.header_found;
  assign out_ch.frame_last     = out_data.frame_last;
  assign out_ch.in_frame       = out_data.in_frame;
  assign out_ch.sample_rate_hz = out_data.sample_rate_hz;
  assign out_ch.channel_config = out_data.channel_config;
  assign out_ch.frame_bytes    = out_data.frame_bytes;

  a_found_not_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.header_found && (out_data.in_frame || out_data.frame_last)))
    else $error("header item flagged as frame body");

  a_lock_after_header: assert property (@(posedge clk) disable iff (rst)
    (in_fire && res.header_found) |=> locked)
    else $error("header found but not locked");

  a_unlocked_count_zero: assert property (@(posedge clk) disable iff (rst)
    !locked |-> (bytes_left == '0))
    else $error("byte counter nonzero while searching");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry without output entry");

  a_no_drop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready && in_fire) |=> (skid_valid && out_valid))
    else $error("item lost while output stalled");

endmodule
